// ----- rtl/pls_pkg.sv -----
// ============================================================================
// pls_pkg: shared types for the path line subdivider
// Holds the job descriptor that passes from the front end to the back end.
// ============================================================================
package pls_pkg;

    localparam logic [7:0] TYPE_MARKER = 8'h20;
    localparam logic [7:0] TYPE_CLOSE  = 8'h80;
    localparam logic [7:0] TYPE_START  = 8'h00;

    localparam int unsigned CW = 20;

    typedef struct packed {
        logic signed [CW-1:0] prev_x;
        logic signed [CW-1:0] prev_y;
        logic signed [CW-1:0] cur_x;
        logic signed [CW-1:0] cur_y;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic                 new_fig;
        logic                 marker;
        logic                 closing;
    } t_job;

endpackage

// ----- rtl/pls_front.sv -----
// ============================================================================
// pls_front: point intake and classification
// Tracks the previous point and the figure start, and turns each point that
// follows a previous one into a segment job for the back end.
// ============================================================================
module pls_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [19:0] i_x,
    input  logic signed [19:0] i_y,
    input  logic [7:0]        i_point_type,
    output logic              o_job_valid,
    input  logic              i_job_stall,
    output pls_pkg::t_job     o_job
);

    logic signed [19:0] r_prev_x, r_prev_y, r_start_x, r_start_y;
    logic               r_have_prev, r_prev_was_start;
    logic               r_job_valid;
    pls_pkg::t_job      r_job;
    logic               w_acc;
    logic               w_close;

    assign o_stall     = r_job_valid && i_job_stall;
    assign w_acc       = i_valid && !o_stall;
    assign w_close     = (i_point_type & pls_pkg::TYPE_CLOSE) != 8'h00;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x         <= '0;
            r_prev_y         <= '0;
            r_start_x        <= '0;
            r_start_y        <= '0;
            r_have_prev      <= 1'b0;
            r_prev_was_start <= 1'b0;
            r_job_valid      <= 1'b0;
        end else begin
            if (r_job_valid && !i_job_stall) begin
                r_job_valid <= 1'b0;
            end
            if (w_acc) begin
                if (r_have_prev) begin
                    r_job_valid    <= 1'b1;
                    r_job.prev_x   <= r_prev_x;
                    r_job.prev_y   <= r_prev_y;
                    r_job.cur_x    <= i_x;
                    r_job.cur_y    <= i_y;
                    r_job.start_x  <= r_start_x;
                    r_job.start_y  <= r_start_y;
                    r_job.new_fig  <= r_prev_was_start;
                    r_job.marker   <= (i_point_type & pls_pkg::TYPE_MARKER) != 8'h00;
                    r_job.closing  <= w_close;
                end
                if (r_have_prev && w_close) begin
                    r_have_prev      <= 1'b0;
                    r_prev_was_start <= 1'b0;
                end else begin
                    r_have_prev      <= 1'b1;
                    r_prev_x         <= i_x;
                    r_prev_y         <= i_y;
                    r_prev_was_start <= (i_point_type == pls_pkg::TYPE_START);
                    if (i_point_type == pls_pkg::TYPE_START) begin
                        r_start_x <= i_x;
                        r_start_y <= i_y;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/pls_back.sv -----
// ============================================================================
// pls_back: segment subdivision engine
// Computes length by a bit-serial square root, the piece count by a serial
// divider, and the piece ends by serial rounded division of d * k by N.
// ============================================================================
module pls_back #(
    parameter int MAX_SUBDIV = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_stall,
    input  pls_pkg::t_job      i_job,
    input  logic [15:0]        i_seg_interval,
    input  logic [15:0]        i_close_interval,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_from_x,
    output logic signed [19:0] o_from_y,
    output logic signed [19:0] o_to_x,
    output logic signed [19:0] o_to_y,
    output logic               o_new_figure,
    output logic               o_marker,
    output logic               o_close_figure,
    output logic               o_last
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SQRT = 8'b00000010,
        S_DIV  = 8'b00000100,
        S_MUL  = 8'b00001000,
        S_LDIV = 8'b00010000,
        S_EMIT = 8'b00100000,
        S_WAIT = 8'b01000000,
        S_RND  = 8'b10000000
    } t_state;

    t_state             r_state;
    pls_pkg::t_job      r_job;
    logic               r_phase;
    logic signed [19:0] r_ax, r_ay, r_bx, r_by, r_fx, r_fy, r_tx, r_ty;
    logic [61:0]        r_sq;
    logic [31:0]        r_root;
    logic [62:0]        r_rem;
    logic [4:0]         r_cnt;
    logic [31:0]        r_quo;
    logic [16:0]        r_drem;
    logic [4:0]         r_n, r_k;
    logic [25:0]        r_mag_x, r_mag_y;
    logic [25:0]        r_qx, r_qy;
    logic [5:0]         r_lrx, r_lry;
    logic               r_axis;
    logic               r_neg_x, r_neg_y;
    logic               r_out_valid;
    logic signed [19:0] r_o_fx, r_o_fy, r_o_tx, r_o_ty;
    logic               r_o_nf, r_o_mk, r_o_cf, r_o_last;
    logic               r_held, r_h_nf;
    logic signed [19:0] r_h_fx, r_h_fy;

    logic signed [20:0] w_dx, w_dy;
    logic [20:0]        w_adx, w_ady;
    logic [15:0]        w_int;
    logic [64:0]        w_trial;
    logic [17:0]        w_dshift;
    logic [25:0]        w_num_x, w_num_y;
    logic [5:0]         w_lshift_x, w_lshift_y;
    logic               w_last_piece, w_final_emit;
    logic               w_out_free;
    logic signed [20:0] w_rx, w_ry;

    assign w_dx  = 21'(r_bx) - 21'(r_ax);
    assign w_dy  = 21'(r_by) - 21'(r_ay);
    assign w_adx = w_dx[20] ? 21'(-w_dx) : 21'(w_dx);
    assign w_ady = w_dy[20] ? 21'(-w_dy) : 21'(w_dy);
    assign w_int = (r_phase ? i_close_interval : i_seg_interval) == 16'd0 ? 16'd1
                 : (r_phase ? i_close_interval : i_seg_interval);

    assign w_trial  = {r_rem, r_sq[61:60]} - 65'({r_root, 2'b01});
    assign w_dshift = {r_drem, r_quo[31]};
    assign w_num_x  = r_mag_x + 26'(r_n >> 1);
    assign w_num_y  = r_mag_y + 26'(r_n >> 1);
    assign w_lshift_x = {r_lrx[4:0], r_qx[25]};
    assign w_lshift_y = {r_lry[4:0], r_qy[25]};
    assign w_rx = r_neg_x ? 21'(r_ax) - 21'(r_qx) : 21'(r_ax) + 21'(r_qx);
    assign w_ry = r_neg_y ? 21'(r_ay) - 21'(r_qy) : 21'(r_ay) + 21'(r_qy);

    assign w_last_piece = r_phase ? (r_k == r_n - 5'd1) : (r_k == r_n);
    assign w_final_emit = w_last_piece &&
                          (r_phase || !r_job.closing);
    assign w_out_free   = !r_out_valid || !i_stall;

    assign o_job_stall    = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_from_x       = r_o_fx;
    assign o_from_y       = r_o_fy;
    assign o_to_x         = r_o_tx;
    assign o_to_y         = r_o_ty;
    assign o_new_figure   = r_o_nf;
    assign o_marker       = r_o_mk;
    assign o_close_figure = r_o_cf;
    assign o_last         = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_ax    <= i_job.prev_x;
                        r_ay    <= i_job.prev_y;
                        r_bx    <= i_job.cur_x;
                        r_by    <= i_job.cur_y;
                        r_phase <= 1'b0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_sq    <= 62'(w_adx * w_adx) + 62'(w_ady * w_ady);
                    r_root  <= '0;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_fx    <= r_ax;
                    r_fy    <= r_ay;
                    r_neg_x <= w_dx[20];
                    r_neg_y <= w_dy[20];
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_sq <= {r_sq[59:0], 2'b00};
                    if (!w_trial[64]) begin
                        r_rem  <= w_trial[62:0];
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[60:0], r_sq[61:60]};
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_cnt   <= '0;
                        r_state <= S_RND;
                        r_drem  <= '0;
                    end
                end
                S_RND: begin
                    r_quo   <= r_root + 32'(r_rem > 63'(r_root));
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= {r_quo[30:0], 1'b0};
                    if (w_dshift >= 18'(w_int)) begin
                        r_drem <= 17'(w_dshift - 18'(w_int));
                        r_quo  <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_drem <= w_dshift[16:0];
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_MUL;
                        r_k     <= 5'd1;
                    end
                end
                S_MUL: begin
                    r_mag_x <= 26'(w_adx) * 26'(r_k);
                    r_mag_y <= 26'(w_ady) * 26'(r_k);
                    r_axis  <= 1'b0;
                    r_state <= S_LDIV;
                    r_cnt   <= '0;
                    r_lrx   <= '0;
                    r_lry   <= '0;
                    if (r_k == 5'd1) begin
                        r_n <= (r_quo == 32'd0) ? 5'd1
                             : (r_quo > 32'(MAX_SUBDIV)) ? 5'(MAX_SUBDIV) : r_quo[4:0];
                    end
                end
                S_LDIV: begin
                    if (!r_axis) begin
                        r_qx    <= w_num_x;
                        r_qy    <= w_num_y;
                        r_axis  <= 1'b1;
                    end else begin
                        r_qx <= {r_qx[24:0], 1'b0};
                        r_qy <= {r_qy[24:0], 1'b0};
                        if (w_lshift_x >= 6'(r_n)) begin
                            r_lrx <= w_lshift_x - 6'(r_n);
                            r_qx  <= {r_qx[24:0], 1'b1};
                        end else begin
                            r_lrx <= w_lshift_x;
                        end
                        if (w_lshift_y >= 6'(r_n)) begin
                            r_lry <= w_lshift_y - 6'(r_n);
                            r_qy  <= {r_qy[24:0], 1'b1};
                        end else begin
                            r_lry <= w_lshift_y;
                        end
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd25) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_phase && w_last_piece && r_job.closing) begin
                        r_held  <= 1'b1;
                        r_h_fx  <= r_fx;
                        r_h_fy  <= r_fy;
                        r_h_nf  <= r_k == 5'd1 && r_job.new_fig;
                        r_phase <= 1'b1;
                        r_ax    <= r_job.cur_x;
                        r_ay    <= r_job.cur_y;
                        r_bx    <= r_job.start_x;
                        r_by    <= r_job.start_y;
                        r_state <= S_WAIT;
                    end else if (r_held) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_o_fx   <= r_h_fx;
                            r_o_fy   <= r_h_fy;
                            r_o_tx   <= r_job.cur_x;
                            r_o_ty   <= r_job.cur_y;
                            r_o_nf   <= r_h_nf;
                            r_o_mk   <= r_job.marker;
                            r_o_cf   <= r_n == 5'd1;
                            r_o_last <= r_n == 5'd1;
                            r_held   <= 1'b0;
                            if (r_n == 5'd1) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_fx   <= r_fx;
                        r_o_fy   <= r_fy;
                        r_o_tx   <= 20'(w_rx);
                        r_o_ty   <= 20'(w_ry);
                        r_o_nf   <= !r_phase && r_k == 5'd1 && r_job.new_fig;
                        r_o_mk   <= !r_phase && r_k == r_n && r_job.marker;
                        r_o_cf   <= w_final_emit && r_job.closing;
                        r_o_last <= w_final_emit;
                        r_fx     <= 20'(w_rx);
                        r_fy     <= 20'(w_ry);
                        r_k      <= r_k + 5'd1;
                        r_state  <= S_MUL;
                        if (w_final_emit) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/path_line_subdivider_top.sv -----
// ============================================================================
// path_line_subdivider_top: polyline segment subdivider
// Cuts each polyline segment into equal rounded pieces, with figure closing.
// ============================================================================
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid/o_stall    i_x, i_y, i_point_type
//  output    out        o_valid/i_stall    from/to points and four flags
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
// A segment runs a serial square root, a rounding step and a serial division,
// then a serial rounded divide for each piece. The closing run repeats this.
// Reset is synchronous and clears the state machines and valid flags. The front
// end holds one job, so a new point is taken while the engine still works.
module path_line_subdivider_top #(
    parameter int MAX_SUBDIV = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [19:0] i_x,
    input  logic signed [19:0] i_y,
    input  logic [7:0]         i_point_type,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_from_x,
    output logic signed [19:0] o_from_y,
    output logic signed [19:0] o_to_x,
    output logic signed [19:0] o_to_y,
    output logic               o_new_figure,
    output logic               o_marker,
    output logic               o_close_figure,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic [15:0]   r_seg_interval, r_close_interval;
    logic          w_job_valid, w_job_stall;
    pls_pkg::t_job w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_interval   <= 16'd128;
            r_close_interval <= 16'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_close_interval <= i_cfg_data;
            end else begin
                r_seg_interval <= i_cfg_data;
            end
        end
    end

    pls_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_x, .i_y, .i_point_type,
        .o_job_valid (w_job_valid),
        .i_job_stall (w_job_stall),
        .o_job       (w_job)
    );

    pls_back #(.MAX_SUBDIV(MAX_SUBDIV)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid      (w_job_valid),
        .o_job_stall      (w_job_stall),
        .i_job            (w_job),
        .i_seg_interval   (r_seg_interval),
        .i_close_interval (r_close_interval),
        .o_valid, .i_stall, .o_from_x, .o_from_y, .o_to_x, .o_to_y,
        .o_new_figure, .o_marker, .o_close_figure, .o_last
    );

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_close_figure |-> o_last)
        else $error("close_figure without last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_to_x))
        else $error("stalled result changed");
    a_nf_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_figure |-> !o_close_figure || o_last)
        else $error("flag mix");

endmodule
